FILE: rtl/work_stealing_task_deque_defines.svh
// assertion macros for the deque rtl, used by the pointer logic in wstd_ctrl
`ifndef WORK_STEALING_TASK_DEQUE_DEFINES_SVH
`define WORK_STEALING_TASK_DEQUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSTD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wstd_pkg.sv
// types, constants and pointer helpers of the task deque
`timescale 1ns / 1ps

package wstd_pkg;

	// storage geometry
	localparam int QUEUE_DEPTH = 1024;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	// field widths
	localparam int OP_W = 2;
	localparam int FIRST_W = 10;
	localparam int STOP_W = 11;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP = 2'd1;
	localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;

	// one stored tile
	typedef struct packed {
		logic [FIRST_W-1:0] row_first;
		logic [STOP_W-1:0] row_stop;
		logic [FIRST_W-1:0] col_first;
		logic [STOP_W-1:0] col_stop;
	} tile_t;

	localparam int TILE_W = $bits(tile_t);

	// memory command from the pointer logic
	typedef struct packed {
		logic we;
		logic re;
		ptr_t addr;
		tile_t wdata;
	} mem_cmd_t;

	// result status carried alongside the memory read
	typedef struct packed {
		logic success;
		logic rd;
		logic now_empty;
	} meta_t;

	// circular advance
	function automatic ptr_t ptr_next(ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// circular retreat
	function automatic ptr_t ptr_prev(ptr_t p);
		ptr_t r;
		if (p == '0) begin
			r = PTR_W'(QUEUE_DEPTH - 1);
		end else begin
			r = p - 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: rtl/wstd_req_if.sv
// request channel: operation and tile bounds
`timescale 1ns / 1ps

interface wstd_req_if;
	logic valid;
	logic ready;
	logic [wstd_pkg::OP_W-1:0] operation;
	logic [wstd_pkg::FIRST_W-1:0] row_first;
	logic [wstd_pkg::STOP_W-1:0] row_stop;
	logic [wstd_pkg::FIRST_W-1:0] col_first;
	logic [wstd_pkg::STOP_W-1:0] col_stop;

	modport source (
		output valid, operation, row_first, row_stop, col_first, col_stop,
		input ready
	);

	modport sink (
		input valid, operation, row_first, row_stop, col_first, col_stop,
		output ready
	);
endinterface

FILE: rtl/wstd_rsp_if.sv
// response channel: status and returned tile
`timescale 1ns / 1ps

interface wstd_rsp_if;
	logic valid;
	logic ready;
	logic success;
	logic [wstd_pkg::FIRST_W-1:0] got_row_first;
	logic [wstd_pkg::STOP_W-1:0] got_row_stop;
	logic [wstd_pkg::FIRST_W-1:0] got_col_first;
	logic [wstd_pkg::STOP_W-1:0] got_col_stop;
	logic now_empty;

	modport source (
		output valid, success, got_row_first, got_row_stop, got_col_first,
		got_col_stop, now_empty,
		input ready
	);

	modport sink (
		input valid, success, got_row_first, got_row_stop, got_col_first,
		got_col_stop, now_empty,
		output ready
	);
endinterface

FILE: rtl/wstd_ram.sv
// single-port synchronous ram with registered read
`timescale 1ns / 1ps

module wstd_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 42
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: rtl/wstd_ctrl.sv
// top and bottom pointers, operation decode and memory command
`timescale 1ns / 1ps
`include "work_stealing_task_deque_defines.svh"

module wstd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [wstd_pkg::OP_W-1:0] operation,
	input  wstd_pkg::tile_t           tile,
	output wstd_pkg::mem_cmd_t        cmd,
	output wstd_pkg::meta_t           meta
);

	wstd_pkg::ptr_t top_q;
	wstd_pkg::ptr_t bottom_q;
	wstd_pkg::ptr_t top_d;
	wstd_pkg::ptr_t bottom_d;
	logic           full;
	logic           empty;

	assign full = (wstd_pkg::ptr_next(top_q) == bottom_q);
	assign empty = (top_q == bottom_q);

	// decode: pick address, next pointers and status
	always_comb begin
		top_d = top_q;
		bottom_d = bottom_q;
		cmd.we = 1'b0;
		cmd.re = 1'b0;
		cmd.addr = top_q;
		cmd.wdata = tile;
		meta.success = 1'b0;
		meta.rd = 1'b0;
		case (operation)
			wstd_pkg::OP_PUSH: begin
				if (!full) begin
					meta.success = 1'b1;
					cmd.we = accept;
					top_d = wstd_pkg::ptr_next(top_q);
				end
			end
			wstd_pkg::OP_POP: begin
				if (!empty) begin
					meta.success = 1'b1;
					meta.rd = 1'b1;
					top_d = wstd_pkg::ptr_prev(top_q);
					cmd.addr = top_d;
					cmd.re = accept;
				end
			end
			wstd_pkg::OP_STEAL: begin
				if (!empty) begin
					meta.success = 1'b1;
					meta.rd = 1'b1;
					cmd.addr = bottom_q;
					cmd.re = accept;
					bottom_d = wstd_pkg::ptr_next(bottom_q);
				end
			end
			default: begin
				meta.success = 1'b0;
			end
		endcase
		meta.now_empty = (top_d == bottom_d);
	end

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			bottom_q <= '0;
		end else if (accept) begin
			top_q <= top_d;
			bottom_q <= bottom_d;
		end
	end

	// pointer checks
	`WSTD_ASSERT_NEXT(a_push_moves_top,
		accept && operation == wstd_pkg::OP_PUSH && meta.success,
		top_q == wstd_pkg::ptr_next($past(top_q)) && $stable(bottom_q),
		"push did not advance top alone")
	`WSTD_ASSERT_NEXT(a_steal_moves_bottom,
		accept && operation == wstd_pkg::OP_STEAL && meta.success,
		bottom_q == wstd_pkg::ptr_next($past(bottom_q)) && $stable(top_q),
		"steal did not advance bottom alone")
	`WSTD_ASSERT_NEXT(a_fail_holds,
		accept && !meta.success,
		$stable(top_q) && $stable(bottom_q),
		"failed operation moved a pointer")
	`WSTD_ASSERT_SAME(a_no_access_on_fail,
		!meta.success,
		!cmd.we && !cmd.re,
		"memory accessed by a failed operation")

endmodule

FILE: rtl/work_stealing_task_deque.sv
// Work-stealing task deque: circular store of tile tasks with owner and thief ends.
// Usage:
//   req carries an operation (push, pop, steal) and, for push, the tile bounds.
//   rsp returns one result per transfer on req: success flag, the popped or
//   stolen tile (zero for push, failures and unknown codes) and whether the
//   deque is empty afterwards. Push is refused when depth minus one tiles are held.
// Timing:
//   one request is taken every cycle while req ready is high; its result is
//   registered first by the memory read port at the transfer, then by the output
//   register once rsp has room. The pointers live in flip-flops and are
//   updated at the transfer, so the next request sees them at once; the single
//   memory port handles the one read or write of each request.
// Reset:
//   arst_n clears both pointers and all valid flags; the deque starts empty.
//   The tile memory is not cleared and is only read at entries already written.
// Backpressure:
//   while rsp is stalled the output register holds its result, one more
//   result waits in the read stage, and req ready drops until room frees up.
`timescale 1ns / 1ps

module work_stealing_task_deque (
	input  logic              clk,
	input  logic              arst_n,
	wstd_req_if.sink          req,
	wstd_rsp_if.source        rsp
);

	logic               accept;
	logic               s1_adv;
	logic               valid_s1;
	wstd_pkg::meta_t    meta;
	wstd_pkg::meta_t    meta_s1;
	wstd_pkg::mem_cmd_t cmd;
	wstd_pkg::tile_t    tile;
	wstd_pkg::tile_t    rdata;
	logic               out_valid_q;
	logic               out_success_q;
	logic               out_empty_q;
	wstd_pkg::tile_t    out_tile_q;

	// handshake between stages
	assign s1_adv = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || !out_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	assign tile.row_first = req.row_first;
	assign tile.row_stop = req.row_stop;
	assign tile.col_first = req.col_first;
	assign tile.col_stop = req.col_stop;

	wstd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (req.operation),
		.tile      (tile),
		.cmd       (cmd),
		.meta      (meta)
	);

	wstd_ram #(
		.DEPTH (wstd_pkg::QUEUE_DEPTH),
		.WIDTH (wstd_pkg::TILE_W)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.re    (cmd.re),
		.addr  (cmd.addr),
		.wdata (cmd.wdata),
		.rdata (rdata)
	);

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage status
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, tile zeroed unless read
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_success_q <= meta_s1.success;
			out_empty_q <= meta_s1.now_empty;
			out_tile_q <= meta_s1.rd ? rdata : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.success = out_success_q;
	assign rsp.got_row_first = out_tile_q.row_first;
	assign rsp.got_row_stop = out_tile_q.row_stop;
	assign rsp.got_col_first = out_tile_q.col_first;
	assign rsp.got_col_stop = out_tile_q.col_stop;
	assign rsp.now_empty = out_empty_q;

endmodule

FILE: sim/tb_work_stealing_task_deque.sv
// self-checking testbench for the work-stealing task deque
`timescale 1ns / 1ps

module tb_work_stealing_task_deque;

	// code that no operation uses, the block must leave the deque alone
	localparam logic [wstd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int LONG_HOLD_AT = 40;

	typedef logic [wstd_pkg::OP_W-1:0] op_t;
	typedef logic [wstd_pkg::FIRST_W-1:0] first_t;
	typedef logic [wstd_pkg::STOP_W-1:0] stop_t;

	// what one transfer on rsp should carry
	typedef struct packed {
		logic success;
		wstd_pkg::tile_t tile;
		logic now_empty;
	} outcome_t;

	// mirror of the deque plus the results still owed by the block
	class tile_deque_tracker;
		wstd_pkg::tile_t slots [wstd_pkg::QUEUE_DEPTH];
		int unsigned top_ptr;
		int unsigned bottom_ptr;
		outcome_t expected_results [$];
		int mismatches;
		int results_checked;

		function new();
			top_ptr = 0;
			bottom_ptr = 0;
			mismatches = 0;
			results_checked = 0;
		endfunction

		function int unsigned held();
			return (top_ptr + wstd_pkg::QUEUE_DEPTH - bottom_ptr) % wstd_pkg::QUEUE_DEPTH;
		endfunction

		// apply one accepted request and queue the result it must produce
		function void note_request(op_t op, wstd_pkg::tile_t t);
			outcome_t o;
			o = '0;
			case (op)
			wstd_pkg::OP_PUSH: begin
				if ((top_ptr + 1) % wstd_pkg::QUEUE_DEPTH != bottom_ptr) begin
					slots[top_ptr] = t;
					top_ptr = (top_ptr + 1) % wstd_pkg::QUEUE_DEPTH;
					o.success = 1'b1;
				end
			end
			wstd_pkg::OP_POP: begin
				if (top_ptr != bottom_ptr) begin
					top_ptr = (top_ptr + wstd_pkg::QUEUE_DEPTH - 1) % wstd_pkg::QUEUE_DEPTH;
					o.tile = slots[top_ptr];
					o.success = 1'b1;
				end
			end
			wstd_pkg::OP_STEAL: begin
				if (top_ptr != bottom_ptr) begin
					o.tile = slots[bottom_ptr];
					bottom_ptr = (bottom_ptr + 1) % wstd_pkg::QUEUE_DEPTH;
					o.success = 1'b1;
				end
			end
			default: begin
			end
			endcase
			o.now_empty = (top_ptr == bottom_ptr);
			expected_results.push_back(o);
		endfunction

		function void compare_field(string label, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, label, want, got);
			end
		endfunction

		// compare one transfer on rsp with the oldest owed result
		function void check_result(outcome_t got);
			outcome_t want;
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result mismatch, expected none, actual %0h", $time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("success", want.success, got.success);
			compare_field("got_row_first", want.tile.row_first, got.tile.row_first);
			compare_field("got_row_stop", want.tile.row_stop, got.tile.row_stop);
			compare_field("got_col_first", want.tile.col_first, got.tile.col_first);
			compare_field("got_col_stop", want.tile.col_stop, got.tile.col_stop);
			compare_field("now_empty", want.now_empty, got.now_empty);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	wstd_req_if req_bus ();
	wstd_rsp_if rsp_bus ();

	tile_deque_tracker tracker;
	bit quiet;
	bit gappy;
	bit long_hold_done;
	int stall_left;
	int idle_cycles;
	int unsigned items_sent;

	work_stealing_task_deque DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	always #5 clk = ~clk;

	function automatic wstd_pkg::tile_t mk_tile(int unsigned rf, int unsigned rs,
		int unsigned cf, int unsigned cs);
		wstd_pkg::tile_t t;
		t.row_first = first_t'(rf);
		t.row_stop = stop_t'(rs);
		t.col_first = first_t'(cf);
		t.col_stop = stop_t'(cs);
		return t;
	endfunction

	// mostly in-range bounds, now and then raw bits across the whole width
	function automatic wstd_pkg::tile_t random_tile();
		wstd_pkg::tile_t t;
		bit raw;
		raw = ($urandom_range(0, 7) == 0);
		t.row_first = first_t'($urandom_range(0, 1023));
		t.row_stop = stop_t'(raw ? $urandom_range(0, 2047) : $urandom_range(0, 1024));
		t.col_first = first_t'($urandom_range(0, 1023));
		t.col_stop = stop_t'(raw ? $urandom_range(0, 2047) : $urandom_range(0, 1024));
		return t;
	endfunction

	function automatic op_t pick_op(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			return wstd_pkg::OP_PUSH;
		end else if (r < push_pct + (95 - push_pct) / 2) begin
			return wstd_pkg::OP_POP;
		end else if (r < 95) begin
			return wstd_pkg::OP_STEAL;
		end
		return OP_UNUSED;
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send_item(op_t op, wstd_pkg::tile_t t);
		int unsigned gap;
		gap = 0;
		if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
		end
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.operation <= op;
		req_bus.row_first <= t.row_first;
		req_bus.row_stop <= t.row_stop;
		req_bus.col_first <= t.col_first;
		req_bus.col_stop <= t.col_stop;
		do @(posedge clk); while (!req_bus.ready);
		tracker.note_request(op, t);
		items_sent++;
		if (items_sent % 32 == 0) begin
			gappy = ($urandom_range(0, 2) != 0);
		end
	endtask

	// stop offering until every owed result has come back
	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_results.size() != 0);
	endtask

	// response side: check each transfer, stall in bursts, one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				tracker.check_result({rsp_bus.success, rsp_bus.got_row_first,
					rsp_bus.got_row_stop, rsp_bus.got_col_first, rsp_bus.got_col_stop,
					rsp_bus.now_empty});
			end
			if (!long_hold_done && tracker.results_checked == LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				rsp_bus.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && gappy && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 5);
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("work_stealing_task_deque regression: fail");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int unsigned rnd_items;
		int weight;
		clk = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.operation = wstd_pkg::OP_PUSH;
		req_bus.row_first = '0;
		req_bus.row_stop = '0;
		req_bus.col_first = '0;
		req_bus.col_stop = '0;
		rsp_bus.ready = 1'b0;
		quiet = 1'b0;
		gappy = 1'b1;
		long_hold_done = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		items_sent = 0;
		rnd_items = 0;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty deque, field extremes, ordering at both ends
		send_item(wstd_pkg::OP_POP, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_STEAL, mk_tile(0, 0, 0, 0));
		send_item(OP_UNUSED, mk_tile(1023, 2047, 1023, 2047));
		send_item(wstd_pkg::OP_PUSH, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_PUSH, mk_tile(1023, 2047, 1023, 2047));
		send_item(wstd_pkg::OP_PUSH, mk_tile(1023, 1024, 1023, 1024));
		send_item(OP_UNUSED, mk_tile(5, 6, 7, 8));
		send_item(wstd_pkg::OP_POP, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_STEAL, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_POP, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_POP, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_PUSH, mk_tile('h2AA, 'h555, 'h155, 'h2AA));
		send_item(wstd_pkg::OP_PUSH, mk_tile('h155, 'h2AA, 'h2AA, 'h555));
		send_item(wstd_pkg::OP_PUSH, mk_tile(1, 1024, 0, 1));
		send_item(wstd_pkg::OP_STEAL, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_POP, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_STEAL, mk_tile(0, 0, 0, 0));
		send_item(wstd_pkg::OP_STEAL, mk_tile(0, 0, 0, 0));

		// mixed traffic, the long rsp hold-off lands in here
		while (rnd_items < 40) begin
			case ($urandom_range(0, 2))
			0: weight = 20;
			1: weight = 45;
			default: weight = 70;
			endcase
			repeat ($urandom_range(10, 40)) begin
				send_item(pick_op(weight), random_tile());
				rnd_items++;
			end
		end

		// pause until idle, then fill to capacity and push into a full deque
		wait_drained();
		while (tracker.held() < wstd_pkg::QUEUE_DEPTH - 1) begin
			send_item(wstd_pkg::OP_PUSH, random_tile());
			rnd_items++;
		end
		repeat (3) begin
			send_item(wstd_pkg::OP_PUSH, random_tile());
			rnd_items++;
		end

		// closing stretch at full rate on both sides
		quiet = 1'b1;
		repeat (40) begin
			send_item(pick_op(50), random_tile());
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
			$display("work_stealing_task_deque regression: pass");
		end else begin
			$display("work_stealing_task_deque regression: fail");
		end
		$finish;
	end

endmodule
